[rtl/core/histogram_equalizer_assert.svh]
// ----------------------------------------------------------------------------
// Histogram equalizer assertion macros
// Shared property forms for the checker; clk and rst_n are taken from scope.
// ----------------------------------------------------------------------------
`ifndef HISTOGRAM_EQUALIZER_ASSERT_SVH
`define HISTOGRAM_EQUALIZER_ASSERT_SVH

// same-cycle implication
`define HEQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram_equalizer assertion failed");

// next-cycle implication
`define HEQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram_equalizer assertion failed");

`endif

[rtl/core/heq_pkg.sv]
// ----------------------------------------------------------------------------
// Histogram equalizer package
// Request kinds and fixed field widths shared by the block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package heq_pkg;

    localparam int PIXEL_W = 8;

    localparam logic REQ_ACCUMULATE = 1'b0;
    localparam logic REQ_MAP        = 1'b1;

endpackage

`default_nettype wire

[rtl/core/heq_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
`default_nettype none

module heq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/histogram_equalizer.sv]
// ----------------------------------------------------------------------------
// Histogram equalizer
// Two-pass gray-level equalizer: accumulate a histogram, build the table,
// map pixels through it.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tdata carries the pixel, tuser the request kind
//   (accumulate or map), tlast the last pixel of a pass. Output stream
//   m_axis: one result per map request, tdata the equalized level, tlast
//   copied from the map request. Accumulate requests give no result.
//   A new accumulate or map request can be taken before the last one is done;
//   a map result passes stage one and the table read, then the output register.
//   The accumulate request with tlast starts the table build, with tready low
//   throughout: for each bin the bin memory read, the cumulative add, the
//   multiply, the bit-per-cycle divider and the table write.
//   The map request with tlast starts a histogram clear over all LEVELS bins.
//   After reset a clearing pass over all LEVELS entries zeroes the histogram and
//   the table before the first request is taken.
//   When the receiver stalls, the output register holds; one further map
//   result waits at the table read port and intake stops until it moves.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_equalizer
    import heq_pkg::*;
#(
    parameter int LEVELS     = 256,
    parameter int COUNT_BITS = 20
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [PIXEL_W-1:0] s_axis_tdata,   // [7:0] pixel_value
    input  wire logic               s_axis_tuser,   // [0] req_type
    input  wire logic               s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic      [PIXEL_W-1:0] m_axis_tdata,   // [7:0] mapped_pixel
    output logic                    m_axis_tlast
);

    localparam int LW    = $clog2(LEVELS);
    localparam int PW    = (LW > PIXEL_W) ? LW : PIXEL_W;
    localparam int NUMW  = COUNT_BITS + LW + 1;
    localparam int STEPW = (LW > 1) ? $clog2(LW) : 1;

    localparam logic [NUMW-1:0]       MUL_K     = NUMW'(2 * (LEVELS - 1));
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [LW-1:0]         LAST_IDX  = LW'(LEVELS - 1);
    localparam logic [PW-1:0]         LAST_PIX  = PW'(LEVELS - 1);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_RUN,
        ST_SETTLE,
        ST_RD,
        ST_CDF,
        ST_MUL,
        ST_DIV,
        ST_WR,
        ST_CLEAR
    } state_t;

    state_t                  state_reg,     state_next;
    logic [LW-1:0]           idx_reg,       idx_next;
    logic [STEPW-1:0]        step_reg,      step_next;
    logic [COUNT_BITS-1:0]   total_reg,     total_next;
    logic [COUNT_BITS-1:0]   cdf_reg,       cdf_next;
    logic [NUMW-1:0]         rem_reg,       rem_next;
    logic [NUMW-1:0]         dsh_reg,       dsh_next;
    logic [LW-1:0]           quo_reg,       quo_next;
    logic                    s1_acc_reg,    s1_acc_next;
    logic                    s1_map_reg,    s1_map_next;
    logic                    s1_last_reg,   s1_last_next;
    logic [LW-1:0]           s1_idx_reg,    s1_idx_next;
    logic                    fwd_valid_reg, fwd_valid_next;
    logic [LW-1:0]           fwd_idx_reg,   fwd_idx_next;
    logic [COUNT_BITS-1:0]   fwd_data_reg,  fwd_data_next;
    logic                    out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0]      out_data_reg,  out_data_next;
    logic                    out_last_reg,  out_last_next;

    logic                    in_fire;
    logic                    is_acc;
    logic                    s1_stall;
    logic                    out_load;
    logic [PW-1:0]           pix_ext;
    logic [LW-1:0]           pix_idx;
    logic [LW-1:0]           idx_inc;

    logic                    bin_we;
    logic [LW-1:0]           bin_waddr;
    logic [COUNT_BITS-1:0]   bin_wdata;
    logic                    bin_re;
    logic [LW-1:0]           bin_raddr;
    logic [COUNT_BITS-1:0]   bin_rdata;
    logic [COUNT_BITS-1:0]   bin_old;
    logic [COUNT_BITS-1:0]   bin_inc;

    logic                    tab_we;
    logic [PIXEL_W-1:0]      tab_wdata;
    logic                    tab_re;
    logic [PIXEL_W-1:0]      tab_rdata;

    logic [COUNT_BITS:0]     cdf_sum;
    logic [NUMW-1:0]         cdf_ext;
    logic [NUMW-1:0]         num_prod;
    logic                    div_ge;

    // request side
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign is_acc   = (s_axis_tuser == REQ_ACCUMULATE);
    assign s1_stall = s1_map_reg && out_valid_reg && !m_axis_tready;
    assign out_load = s1_map_reg && !s1_stall;

    assign s_axis_tready = (state_reg == ST_RUN) && !s1_stall;

    assign pix_ext = PW'(s_axis_tdata);
    assign pix_idx = (pix_ext > LAST_PIX) ? LAST_IDX : LW'(pix_ext);
    assign idx_inc = LW'(idx_reg + 1'b1);

    // histogram read-modify-write with forwarding of the previous write
    assign bin_old = (fwd_valid_reg && (fwd_idx_reg == s1_idx_reg)) ? fwd_data_reg : bin_rdata;
    assign bin_inc = (bin_old == COUNT_MAX) ? bin_old : COUNT_BITS'(bin_old + 1'b1);

    assign bin_re    = (in_fire && is_acc) || (state_reg == ST_RD);
    assign bin_raddr = (state_reg == ST_RD) ? idx_reg : pix_idx;
    assign bin_we    = s1_acc_reg || (state_reg == ST_CLEAR) || (state_reg == ST_INIT);
    assign bin_waddr = s1_acc_reg ? s1_idx_reg : idx_reg;
    assign bin_wdata = s1_acc_reg ? bin_inc : '0;

    // level table
    assign tab_re    = in_fire && !is_acc;
    assign tab_we    = (state_reg == ST_WR) || (state_reg == ST_INIT);
    assign tab_wdata = ((state_reg == ST_INIT) || (total_reg == '0)) ? '0
                                                                      : PIXEL_W'(quo_reg);

    // table build datapath
    assign cdf_sum  = {1'b0, cdf_reg} + {1'b0, bin_rdata};
    assign cdf_ext  = NUMW'(cdf_reg);
    assign num_prod = MUL_K * cdf_ext;
    assign div_ge   = (rem_reg >= dsh_reg);

    heq_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (LEVELS)
    ) u_bin_ram (
        .clk   (clk),
        .we    (bin_we),
        .waddr (bin_waddr),
        .wdata (bin_wdata),
        .re    (bin_re),
        .raddr (bin_raddr),
        .rdata (bin_rdata)
    );

    heq_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (LEVELS)
    ) u_tab_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (idx_reg),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (pix_idx),
        .rdata (tab_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        total_next     = total_reg;
        cdf_next       = cdf_reg;
        rem_next       = rem_reg;
        dsh_next       = dsh_reg;
        quo_next       = quo_reg;
        s1_acc_next    = s1_acc_reg;
        s1_map_next    = s1_map_reg;
        s1_last_next   = s1_last_reg;
        s1_idx_next    = s1_idx_reg;
        fwd_valid_next = s1_acc_reg;
        fwd_idx_next   = s1_idx_reg;
        fwd_data_next  = bin_inc;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        // stage one advances unless a map result is blocked
        if (!s1_stall)
        begin
            s1_acc_next  = in_fire && is_acc;
            s1_map_next  = in_fire && !is_acc;
            s1_last_next = s_axis_tlast;
            s1_idx_next  = pix_idx;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = tab_rdata;
            out_last_next  = s1_last_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            if (is_acc)
            begin
                total_next = (total_reg == COUNT_MAX) ? total_reg
                                                      : COUNT_BITS'(total_reg + 1'b1);
            end
            else if (s_axis_tlast)
            begin
                total_next = '0;
            end
        end

        case (state_reg)
            ST_INIT:
            begin
                idx_next = idx_inc;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (in_fire && s_axis_tlast)
                begin
                    state_next = is_acc ? ST_SETTLE : ST_CLEAR;
                end
            end
            ST_SETTLE:
            begin
                cdf_next   = '0;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_CDF;
            end
            ST_CDF:
            begin
                cdf_next   = cdf_sum[COUNT_BITS] ? COUNT_MAX : cdf_sum[COUNT_BITS-1:0];
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                rem_next   = num_prod + NUMW'(total_reg);
                dsh_next   = NUMW'(total_reg) << LW;
                quo_next   = '0;
                step_next  = STEPW'(LW - 1);
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                quo_next = LW'({quo_reg, div_ge});
                dsh_next = dsh_reg >> 1;
                if (step_reg == '0)
                begin
                    state_next = ST_WR;
                end
                else
                begin
                    step_next = STEPW'(step_reg - 1'b1);
                end
            end
            ST_WR:
            begin
                idx_next   = idx_inc;
                state_next = ST_RD;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_RUN;
                end
            end
            ST_CLEAR:
            begin
                idx_next = idx_inc;
                if (idx_reg == LAST_IDX)
                begin
                    idx_next   = '0;
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                idx_next   = '0;
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            idx_reg       <= '0;
            total_reg     <= '0;
            s1_acc_reg    <= 1'b0;
            s1_map_reg    <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            total_reg     <= total_next;
            s1_acc_reg    <= s1_acc_next;
            s1_map_reg    <= s1_map_next;
            fwd_valid_reg <= fwd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg     <= step_next;
        cdf_reg      <= cdf_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        quo_reg      <= quo_next;
        s1_last_reg  <= s1_last_next;
        s1_idx_reg   <= s1_idx_next;
        fwd_idx_reg  <= fwd_idx_next;
        fwd_data_reg <= fwd_data_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

[rtl/core/heq_checker.sv]
// ----------------------------------------------------------------------------
// Histogram equalizer port checker
// Watches the stream ports of the block; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "histogram_equalizer_assert.svh"

module heq_checker
    import heq_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_axis_tvalid,
    input wire logic               s_axis_tready,
    input wire logic               s_axis_tuser,   // [0] req_type
    input wire logic               s_axis_tlast,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [PIXEL_W-1:0] m_axis_tdata,   // [7:0] mapped_pixel
    input wire logic               m_axis_tlast
);

    // a stalled result holds
    `HEQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // a fresh result traces back through stage one to a taken map request
    `HEQ_ASSERT_IMPL(a_out_from_map, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_MAP), 2))

    // the last request of a pass starts a build or a clear
    `HEQ_ASSERT_NEXT(a_busy_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

endmodule

bind histogram_equalizer heq_checker u_heq_checker (.*);

`default_nettype wire
